// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the quaternion unit checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/qau_pkg.sv =====
// Types, constants and saturation helper of the quaternion arithmetic unit.
package qau_pkg;

  // operation codes
  localparam logic [1:0] KIND_MUL  = 2'd0;
  localparam logic [1:0] KIND_INV  = 2'd1;
  localparam logic [1:0] KIND_AXIS = 2'd2;

  // angle constants in Q32
  localparam logic [47:0]        TWO_PI_Q32  = 48'd26986075409;
  localparam logic [47:0]        PI_Q32      = 48'd13493037705;
  localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [35:0] GAIN_Q32    = 36'sd2608131496;

  // 2pi * 4096 lifts the most negative half angle above zero
  localparam logic [47:0] ANGLE_BIAS = TWO_PI_Q32 << 12;
  // conditional subtractions of 2pi << 13 down to 2pi << 0
  localparam int unsigned RED_STEPS = 14;

  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } qau_in_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               zero_magnitude;
    logic               saturated;
  } qau_out_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  // clip a wide signed value to the 32-bit range
  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t o;
    if (v > 66'sd2147483647) begin
      o.clip = 1'b1;
      o.val  = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      o.clip = 1'b1;
      o.val  = 32'sh80000000;
    end else begin
      o.clip = 1'b0;
      o.val  = v[31:0];
    end
    return o;
  endfunction

endpackage

// ===== rtl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit: multiply, inverse and axis-angle, Q16.16, pipelined.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (qau_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (qau_out_t)
//
// One item enters per cycle while in_stall_o is low; the pipeline depth is
// set by the 33-step restoring divider for inverse and by the angle
// reduction plus CORDIC chain for axis-angle.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the output holds the last stage; earlier stages keep advancing
// into bubbles, so input is refused only when every stage holds an item.
`include "assert_macros.svh"

module quaternion_arithmetic_unit #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qau_pkg::qau_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qau_pkg::qau_out_t  out_data_o
);
  import qau_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  // stage map
  localparam int unsigned MUL_DONE  = 3;
  localparam int unsigned DIV_BITS  = 33;
  localparam int unsigned DIV_FIRST = 3;
  localparam int unsigned INV_DONE  = DIV_FIRST + DIV_BITS;
  localparam int unsigned RED_FIRST = 2;
  localparam int unsigned ROT_STAGE = RED_FIRST + RED_STEPS;
  localparam int unsigned CRD_FIRST = ROT_STAGE + 1;
  localparam int unsigned FIN_STAGE = CRD_FIRST + CORDIC_STEPS;
  localparam int unsigned PRD_STAGE = FIN_STAGE + 1;
  localparam int unsigned AX_DONE   = PRD_STAGE + 1;
  localparam int unsigned LAST      = (INV_DONE > AX_DONE) ? INV_DONE : AX_DONE;

  // ---------------------------------------------------------------------
  // Pipeline control: a stage advances when it is empty or its successor
  // advances; the output register advances when empty or not stalled.
  // ---------------------------------------------------------------------
  logic [LAST:0] v_q;
  logic [LAST:0] adv;
  logic [1:0]    kind_q [LAST+1];

  assign adv[LAST] = !v_q[LAST] || !out_stall_i;
  for (genvar s = 0; s < LAST; s++) begin : g_adv
    assign adv[s] = !v_q[s] || adv[s+1];
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      kind_q[0] <= in_data_i.kind;
    end
  end

  for (genvar s = 1; s <= LAST; s++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv[s]) begin
        v_q[s] <= v_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        kind_q[s] <= kind_q[s-1];
      end
    end
  end

  // input register
  qau_in_t in_q;
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      in_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Multiply: sixteen products, then four exact sums, then round half up.
  // ---------------------------------------------------------------------
  logic signed [63:0] mp_d [16];
  logic signed [63:0] mp_q [16];
  logic signed [65:0] ms_d [4];
  logic signed [65:0] ms_q [4];
  qau_out_t           mul_res;
  sat_t               mul_sat [4];

  always_comb begin
    mp_d[0]  = in_q.a_w * in_q.b_w;
    mp_d[1]  = in_q.a_x * in_q.b_x;
    mp_d[2]  = in_q.a_y * in_q.b_y;
    mp_d[3]  = in_q.a_z * in_q.b_z;
    mp_d[4]  = in_q.a_w * in_q.b_x;
    mp_d[5]  = in_q.b_w * in_q.a_x;
    mp_d[6]  = in_q.a_y * in_q.b_z;
    mp_d[7]  = in_q.a_z * in_q.b_y;
    mp_d[8]  = in_q.a_w * in_q.b_y;
    mp_d[9]  = in_q.b_w * in_q.a_y;
    mp_d[10] = in_q.a_z * in_q.b_x;
    mp_d[11] = in_q.a_x * in_q.b_z;
    mp_d[12] = in_q.a_w * in_q.b_z;
    mp_d[13] = in_q.b_w * in_q.a_z;
    mp_d[14] = in_q.a_x * in_q.b_y;
    mp_d[15] = in_q.a_y * in_q.b_x;
  end

  always_comb begin
    ms_d[0] = 66'(mp_q[0]) - 66'(mp_q[1]) - 66'(mp_q[2]) - 66'(mp_q[3]);
    ms_d[1] = 66'(mp_q[4]) + 66'(mp_q[5]) + 66'(mp_q[6]) - 66'(mp_q[7]);
    ms_d[2] = 66'(mp_q[8]) + 66'(mp_q[9]) + 66'(mp_q[10]) - 66'(mp_q[11]);
    ms_d[3] = 66'(mp_q[12]) + 66'(mp_q[13]) + 66'(mp_q[14]) - 66'(mp_q[15]);
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mul_sat[c] = sat32((ms_q[c] + 66'sd32768) >>> 16);
    end
    mul_res.r_w            = mul_sat[0].val;
    mul_res.r_x            = mul_sat[1].val;
    mul_res.r_y            = mul_sat[2].val;
    mul_res.r_z            = mul_sat[3].val;
    mul_res.zero_magnitude = 1'b0;
    mul_res.saturated      = mul_sat[0].clip | mul_sat[1].clip |
                             mul_sat[2].clip | mul_sat[3].clip;
  end

  // ---------------------------------------------------------------------
  // Inverse: magnitudes and squares, sum of squares, then one quotient bit
  // per stage of |c| * 2^32 / M, then round to nearest, ties away.
  // ---------------------------------------------------------------------
  logic signed [31:0] iv_src [4];
  logic [31:0]        iv_mag_d [4];
  logic [31:0]        iv_mag_q [4];
  logic [63:0]        iv_sq_d [4];
  logic [63:0]        iv_sq_q [4];
  logic [3:0]         iv_neg_d;
  logic [3:0]         iv_neg_q;
  logic [31:0]        iv_mag2_q [4];
  logic [3:0]         iv_neg2_q;
  logic [64:0]        iv_m_d;
  logic [64:0]        iv_m_q;
  logic               iv_zero_q;

  assign iv_src[0] = in_q.a_w;
  assign iv_src[1] = in_q.a_x;
  assign iv_src[2] = in_q.a_y;
  assign iv_src[3] = in_q.a_z;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      iv_mag_d[c] = iv_src[c][31] ? (~iv_src[c] + 32'd1) : iv_src[c];
      iv_sq_d[c]  = iv_mag_d[c] * iv_mag_d[c];
      // conjugate: negate the vector part
      iv_neg_d[c] = (c == 0) ? iv_src[c][31] : !iv_src[c][31];
    end
  end

  assign iv_m_d = 65'(iv_sq_q[0]) + 65'(iv_sq_q[1]) + 65'(iv_sq_q[2]) + 65'(iv_sq_q[3]);

  logic [63:0] dv_r_q    [DIV_BITS][4];
  logic [32:0] dv_q_q    [DIV_BITS][4];
  logic [64:0] dv_m_q    [DIV_BITS];
  logic [3:0]  dv_neg_q  [DIV_BITS];
  logic        dv_zero_q [DIV_BITS];

  for (genvar d = 0; d < DIV_BITS; d++) begin : g_div
    logic [63:0] r_in [4];
    logic [32:0] q_in [4];
    logic        b_in [4];
    logic [64:0] m_in;
    logic [3:0]  neg_in;
    logic        zero_in;
    logic [64:0] trial [4];
    logic        ge [4];

    if (d == 0) begin : g_first
      // the numerator's only set bits are the magnitude bits above bit 31
      for (genvar c = 0; c < 4; c++) begin : g_c
        assign r_in[c] = {33'd0, iv_mag2_q[c][31:1]};
        assign q_in[c] = '0;
        assign b_in[c] = iv_mag2_q[c][0];
      end
      assign m_in    = iv_m_q;
      assign neg_in  = iv_neg2_q;
      assign zero_in = iv_zero_q;
    end else begin : g_next
      for (genvar c = 0; c < 4; c++) begin : g_c
        assign r_in[c] = dv_r_q[d-1][c];
        assign q_in[c] = dv_q_q[d-1][c];
        assign b_in[c] = 1'b0;
      end
      assign m_in    = dv_m_q[d-1];
      assign neg_in  = dv_neg_q[d-1];
      assign zero_in = dv_zero_q[d-1];
    end

    always_comb begin
      for (int c = 0; c < 4; c++) begin
        trial[c] = {r_in[c], b_in[c]};
        ge[c]    = (trial[c] >= m_in);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[DIV_FIRST+d]) begin
        for (int c = 0; c < 4; c++) begin
          dv_r_q[d][c] <= ge[c] ? 64'(trial[c] - m_in) : trial[c][63:0];
          dv_q_q[d][c] <= {q_in[c][31:0], ge[c]};
        end
        dv_m_q[d]    <= m_in;
        dv_neg_q[d]  <= neg_in;
        dv_zero_q[d] <= zero_in;
      end
    end
  end

  qau_out_t           inv_res;
  sat_t               inv_sat [4];
  logic               inv_up [4];
  logic [33:0]        inv_qr [4];
  logic signed [65:0] inv_val [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      inv_up[c]  = ({dv_r_q[DIV_BITS-1][c], 1'b0} >= dv_m_q[DIV_BITS-1]);
      inv_qr[c]  = 34'(dv_q_q[DIV_BITS-1][c]) + 34'(inv_up[c]);
      inv_val[c] = dv_neg_q[DIV_BITS-1][c] ? -$signed(66'(inv_qr[c]))
                                           : $signed(66'(inv_qr[c]));
      inv_sat[c] = sat32(inv_val[c]);
    end
    if (dv_zero_q[DIV_BITS-1]) begin
      inv_res                = '0;
      inv_res.zero_magnitude = 1'b1;
    end else begin
      inv_res.r_w            = inv_sat[0].val;
      inv_res.r_x            = inv_sat[1].val;
      inv_res.r_y            = inv_sat[2].val;
      inv_res.r_z            = inv_sat[3].val;
      inv_res.zero_magnitude = 1'b0;
      inv_res.saturated      = inv_sat[0].clip | inv_sat[1].clip |
                               inv_sat[2].clip | inv_sat[3].clip;
    end
  end

  // ---------------------------------------------------------------------
  // Axis-angle: bias the Q32 half angle positive, reduce modulo 2pi by
  // conditional subtraction, fold into [0, pi), rotate, scale the axis.
  // ---------------------------------------------------------------------
  logic signed [47:0] ax_aw48;
  logic [47:0]        ax_u_d;
  logic [47:0]        ax_u_q;
  vec3_t              ax_vec_q [FIN_STAGE+1];

  assign ax_aw48 = 48'(in_q.a_w);
  assign ax_u_d  = {ax_aw48[32:0], 15'd0} + ANGLE_BIAS;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      ax_u_q      <= ax_u_d;
      ax_vec_q[1] <= '{x: in_q.a_x, y: in_q.a_y, z: in_q.a_z};
    end
  end

  for (genvar s = 2; s <= FIN_STAGE; s++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        ax_vec_q[s] <= ax_vec_q[s-1];
      end
    end
  end

  logic [47:0] rd_u_q [RED_STEPS];

  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    localparam logic [47:0] TRIAL = TWO_PI_Q32 << (RED_STEPS - 1 - j);
    logic [47:0] u_in;
    if (j == 0) begin : g_first
      assign u_in = ax_u_q;
    end else begin : g_next
      assign u_in = rd_u_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv[RED_FIRST+j]) begin
        rd_u_q[j] <= (u_in >= TRIAL) ? (u_in - TRIAL) : u_in;
      end
    end
  end

  logic               rt_flip_d;
  logic [47:0]        rt_h;
  logic signed [35:0] rt_z_d;
  logic signed [35:0] rt_z_q;
  logic               rt_flip_q;

  // the upper half turn negates both sine and cosine
  assign rt_flip_d = (rd_u_q[RED_STEPS-1] >= PI_Q32);
  assign rt_h      = rt_flip_d ? (rd_u_q[RED_STEPS-1] - PI_Q32) : rd_u_q[RED_STEPS-1];
  assign rt_z_d    = $signed(rt_h[35:0]) - HALF_PI_Q32;

  always_ff @(posedge clk_i) begin
    if (adv[ROT_STAGE]) begin
      rt_z_q    <= rt_z_d;
      rt_flip_q <= rt_flip_d;
    end
  end

  logic signed [35:0] cx_q [CORDIC_STEPS];
  logic signed [35:0] cy_q [CORDIC_STEPS];
  logic signed [35:0] cz_q [CORDIC_STEPS];
  logic               cf_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [35:0] x_in;
    logic signed [35:0] y_in;
    logic signed [35:0] z_in;
    logic               f_in;
    logic signed [35:0] at;
    logic signed [35:0] x_d;
    logic signed [35:0] y_d;
    logic signed [35:0] z_d;

    if (i == 0) begin : g_first
      assign x_in = GAIN_Q32;
      assign y_in = '0;
      assign z_in = rt_z_q;
      assign f_in = rt_flip_q;
    end else begin : g_next
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign z_in = cz_q[i-1];
      assign f_in = cf_q[i-1];
    end

    assign at = $signed({4'd0, ATAN_Q32[i]});

    always_comb begin
      if (!z_in[35]) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - at;
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[CRD_FIRST+i]) begin
        cx_q[i] <= x_d;
        cy_q[i] <= y_d;
        cz_q[i] <= z_d;
        cf_q[i] <= f_in;
      end
    end
  end

  logic signed [35:0] fn_cs;
  logic signed [35:0] fn_sn;
  logic signed [35:0] fn_s4;
  logic signed [35:0] fn_c16;
  logic signed [33:0] fn_s30_q;
  sat_t               fn_w_q;

  // the rotation ends at angle - pi/2: cosine is -y, sine is x
  assign fn_cs  = cf_q[CORDIC_STEPS-1] ? cy_q[CORDIC_STEPS-1] : -cy_q[CORDIC_STEPS-1];
  assign fn_sn  = cf_q[CORDIC_STEPS-1] ? -cx_q[CORDIC_STEPS-1] : cx_q[CORDIC_STEPS-1];
  assign fn_s4  = fn_sn + 36'sd2;
  assign fn_c16 = fn_cs + 36'sd32768;

  always_ff @(posedge clk_i) begin
    if (adv[FIN_STAGE]) begin
      fn_s30_q <= $signed(fn_s4[35:2]);
      fn_w_q   <= sat32(66'($signed(fn_c16[35:16])));
    end
  end

  logic signed [65:0] pr_d [3];
  logic signed [65:0] pr_q [3];
  sat_t               pr_w_q;

  always_comb begin
    pr_d[0] = ax_vec_q[FIN_STAGE].x * fn_s30_q;
    pr_d[1] = ax_vec_q[FIN_STAGE].y * fn_s30_q;
    pr_d[2] = ax_vec_q[FIN_STAGE].z * fn_s30_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[PRD_STAGE]) begin
      pr_q   <= pr_d;
      pr_w_q <= fn_w_q;
    end
  end

  qau_out_t ax_res;
  sat_t     ax_sat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ax_sat[c] = sat32((pr_q[c] + 66'sd536870912) >>> 30);
    end
    ax_res.r_w            = pr_w_q.val;
    ax_res.r_x            = ax_sat[0].val;
    ax_res.r_y            = ax_sat[1].val;
    ax_res.r_z            = ax_sat[2].val;
    ax_res.zero_magnitude = 1'b0;
    ax_res.saturated      = pr_w_q.clip | ax_sat[0].clip | ax_sat[1].clip | ax_sat[2].clip;
  end

  // ---------------------------------------------------------------------
  // Stage registers of the multiply and inverse paths. Stage 1 and 2 registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      mp_q     <= mp_d;
      iv_mag_q <= iv_mag_d;
      iv_sq_q  <= iv_sq_d;
      iv_neg_q <= iv_neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      ms_q      <= ms_d;
      iv_mag2_q <= iv_mag_q;
      iv_neg2_q <= iv_neg_q;
      iv_m_q    <= iv_m_d;
      iv_zero_q <= (iv_m_d == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Result line: each path drops its result in at the stage where it is
  // done; an unused kind carries zeros from the multiply stage on.
  // ---------------------------------------------------------------------
  qau_out_t res_q [LAST+1];

  for (genvar s = MUL_DONE; s <= LAST; s++) begin : g_res
    qau_out_t base;
    qau_out_t res_d;

    if (s == MUL_DONE) begin : g_first
      assign base = (kind_q[s-1] == KIND_MUL) ? mul_res : '0;
    end else begin : g_next
      assign base = res_q[s-1];
    end

    always_comb begin
      res_d = base;
      if (s == INV_DONE && kind_q[s-1] == KIND_INV) begin
        res_d = inv_res;
      end
      if (s == AX_DONE && kind_q[s-1] == KIND_AXIS) begin
        res_d = ax_res;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        res_q[s] <= res_d;
      end
    end
  end

  assign out_valid_o = v_q[LAST];
  assign out_data_o  = res_q[LAST];

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // input is refused only with every stage full and the output stalled
  `ASSERT_SAME(a_stall_full, in_stall_o, (&v_q) && out_stall_i)
  // a stalled output item stays in the last stage
  `ASSERT_NEXT(a_hold_last, v_q[LAST] && out_stall_i, v_q[LAST] && $stable(kind_q[LAST]))
  // a zero-magnitude flag only comes from an inverse and never with clipping
  `ASSERT_SAME(a_zero_inv, v_q[LAST] && res_q[LAST].zero_magnitude,
               (kind_q[LAST] == KIND_INV) && !res_q[LAST].saturated)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the quaternion arithmetic unit.
`timescale 1ns / 1ps

module tb;
  import qau_pkg::*;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int LATENCY = 43;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint TWO_PI = 64'sd26986075409;
  localparam longint PI = 64'sd13493037705;
  localparam longint HALF_PI = 64'sd6746518852;
  localparam longint GAIN = 64'sd2608131496;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Q32 arctangent table, one entry per CORDIC rotation
  localparam longint ARCTAN [32] = '{
    64'sd3373259426, 1991351318, 1052175346, 534100635, 268086748, 134174063,
    67103403, 33553749, 16777131, 8388597, 4194303, 2097152, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2
  };

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  qau_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  qau_out_t out_data_o;

  quaternion_arithmetic_unit #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clip to 32 bits, flagging any clip.
  function automatic logic signed [31:0] clip_q16(input logic signed [127:0] v,
                                                  inout logic flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Sum four exact Q32.32 products and round half up to Q16.16.
  function automatic logic signed [127:0] round_sum(input logic signed [127:0] p0,
      input logic signed [127:0] p1, input logic signed [127:0] p2,
      input logic signed [127:0] p3);
    return (p0 + p1 + p2 + p3 + 128'sd32768) >>> 16;
  endfunction

  // Compute the expected quaternion result of one operation.
  function automatic qau_out_t quat_result(input qau_in_t q);
    qau_out_t o;
    logic signed [127:0] r [4];
    logic signed [127:0] aw, ax, ay, az, bw, bx, by, bz;
    logic signed [127:0] c [4];
    logic [127:0] msum, mag, num, quo, rem;
    longint h, x, y, z, nx, cs, sn, s30;
    logic flip, sat;
    aw = q.a_w; ax = q.a_x; ay = q.a_y; az = q.a_z;
    bw = q.b_w; bx = q.b_x; by = q.b_y; bz = q.b_z;
    o = '0;
    sat = 1'b0;
    for (int k = 0; k < 4; k++) r[k] = 0;
    case (q.kind)
      KIND_MUL: begin
        r[0] = round_sum(aw * bw, -(ax * bx), -(ay * by), -(az * bz));
        r[1] = round_sum(aw * bx, bw * ax, ay * bz, -(az * by));
        r[2] = round_sum(aw * by, bw * ay, az * bx, -(ax * bz));
        r[3] = round_sum(aw * bz, bw * az, ax * by, -(ay * bx));
      end
      KIND_INV: begin
        c[0] = aw; c[1] = ax; c[2] = ay; c[3] = az;
        msum = 0;
        for (int k = 0; k < 4; k++) msum += c[k] * c[k];
        if (msum == 0) begin
          o.zero_magnitude = 1'b1;
        end else begin
          for (int k = 0; k < 4; k++) begin
            mag = (c[k] < 0) ? -c[k] : c[k];
            num = mag << 32;
            quo = num / msum;
            rem = num % msum;
            // round to nearest, ties away from zero
            if (rem >= msum - rem) quo++;
            r[k] = ((c[k] < 0) != (k != 0)) ? -$signed(quo) : $signed(quo);
          end
        end
      end
      KIND_AXIS: begin
        h = (longint'(q.a_w) * 32768) % TWO_PI;
        if (h < 0) h += TWO_PI;
        flip = (h >= PI);
        if (flip) h -= PI;
        z = h - HALF_PI;
        x = GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ARCTAN[i];
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ARCTAN[i];
          end
          x = nx;
        end
        cs = flip ? y : -y;
        sn = flip ? -x : x;
        s30 = (sn + 2) >>> 2;
        r[0] = (cs + 32768) >>> 16;
        r[1] = (ax * s30 + (128'sd1 << 29)) >>> 30;
        r[2] = (ay * s30 + (128'sd1 << 29)) >>> 30;
        r[3] = (az * s30 + (128'sd1 << 29)) >>> 30;
      end
      default: ;
    endcase
    o.r_w = clip_q16(r[0], sat);
    o.r_x = clip_q16(r[1], sat);
    o.r_y = clip_q16(r[2], sat);
    o.r_z = clip_q16(r[3], sat);
    o.saturated = sat;
    return o;
  endfunction

  // Hold expected results in order and compare each transfer against them.
  class quat_scoreboard;
    qau_out_t pending[$];
    int mismatches;

    function void note_input(qau_in_t q);
      pending.push_back(quat_result(q));
    endfunction

    function void check_result(qau_out_t got);
      qau_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected w=%h x=%h y=%h z=%h zm=%b s=%b,",
                   want.r_w, want.r_x, want.r_y, want.r_z, want.zero_magnitude,
                   want.saturated,
                   " got w=%h x=%h y=%h z=%h zm=%b s=%b",
                   got.r_w, got.r_x, got.r_y, got.r_z,
                   got.zero_magnitude, got.saturated);
      end
    endfunction
  endclass

  quat_scoreboard board = new();
  bit idle_sides = 1'b1;   // cleared for the final stretch
  bit hold_output = 1'b0;  // long receiver hold-off
  longint cycles = 0;

  // Check every output transfer; stall in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  initial begin : receiver
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_stall_i <= 1'b1;
      end else if (idle_sides && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (gap - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Random 32-bit value, biased toward extremes and small numbers.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'sd0 + $signed($urandom_range(0, 'h3ffff)) - 32'sh20000;
      3: return $urandom_range(0, 'h1ffff);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and wait for its transfer.
  task automatic send_item(input qau_in_t q);
    int gap;
    if (idle_sides && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(q);
  endtask

  task automatic send_random(input int count);
    qau_in_t q;
    for (int n = 0; n < count; n++) begin
      q.kind = ($urandom_range(0, 20) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
      q.a_w = pick_value(); q.a_x = pick_value();
      q.a_y = pick_value(); q.a_z = pick_value();
      q.b_w = pick_value(); q.b_x = pick_value();
      q.b_y = pick_value(); q.b_z = pick_value();
      if (q.kind == KIND_INV && $urandom_range(0, 9) == 0) q = '{kind: KIND_INV, default: '0};
      send_item(q);
    end
  endtask

  task automatic drain_results();
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin : sender
    qau_in_t q;
    logic [31:0] edges [4] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h00010000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes of each operation and every special case
    foreach (edges[e]) begin
      q = '{kind: KIND_MUL, default: edges[e]};
      send_item(q);
      q.kind = KIND_INV;
      send_item(q);
      q.kind = KIND_AXIS;
      send_item(q);
    end
    q = '{kind: KIND_INV, default: '0};
    send_item(q);
    q = '{kind: KIND_SPARE, default: 32'h7fffffff};
    send_item(q);
    q = '{kind: KIND_AXIS, a_w: 32'h0003243f, a_x: 32'h00010000, default: '0};
    send_item(q);
    q = '{kind: KIND_AXIS, a_w: 32'hfffcdbc1, a_y: 32'hffff0000, default: '0};
    send_item(q);
    // pause until every expected result has come
    in_valid_i <= 1'b0;
    drain_results();
    send_random(500);
    // hold off the receiver so the pipeline fills and refuses input
    fork
      begin
        hold_output = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_output = 1'b0;
      end
      send_random(150);
    join
    send_random(400);
    idle_sides = 1'b0;
    send_random(200);
    in_valid_i <= 1'b0;
    drain_results();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
